// File: hw/rtl/assert_macros.svh
// assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked on every clock, disabled in reset
`define ASSERT_IMPL(label, clk, rstn, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) \
    else $error("assertion failed");
// next-cycle implication
`define ASSERT_NEXT(label, clk, rstn, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
    else $error("assertion failed");
`endif

// File: hw/rtl/acu_pkg.sv
// shared types, constants and tables of the audio channel control unit
package acu_pkg;
  typedef enum logic [1:0] {
    OP_WRITE = 2'd0, OP_READ = 2'd1, OP_TIMER = 2'd2, OP_QUARTER = 2'd3
  } op_e;

  localparam logic [4:0] A_P1_CTRL = 5'h00, A_P1_SWEEP = 5'h01, A_P1_LO = 5'h02,
    A_P1_HI = 5'h03, A_P2_CTRL = 5'h04, A_P2_SWEEP = 5'h05, A_P2_LO = 5'h06,
    A_P2_HI = 5'h07, A_TRI_LIN = 5'h08, A_TRI_LO = 5'h0A, A_TRI_HI = 5'h0B,
    A_NS_CTRL = 5'h0C, A_NS_PER = 5'h0E, A_NS_LEN = 5'h0F, A_STATUS = 5'h15,
    A_FRAME = 5'h17;

  localparam logic [3:0] DECAY_FULL = 4'd15;
  localparam logic [2:0] PRESCALE_RELOAD = 3'd6;
  localparam logic [10:0] PERIOD_MIN = 11'd8;

  typedef struct packed {
    logic [3:0] rdata;
    logic [3:0] pulse1_volume;
    logic [3:0] pulse2_volume;
    logic [3:0] noise_volume;
    logic [3:0] gate_mask;
    logic [10:0] pulse1_period;
    logic [10:0] pulse2_period;
    logic [10:0] triangle_period;
    logic [3:0] duty_pair;
  } result_t;

  typedef struct packed {
    logic       start;
    logic       loop;
    logic       constant;
    logic [3:0] level;
    logic [3:0] divider;
    logic [3:0] decay;
    logic [3:0] amplitude;
  } env_t;

  function automatic logic [7:0] len_lookup(input logic [4:0] i);
    logic [7:0] r;
    case (i)
      5'd0: r = 8'd10;   5'd1: r = 8'd254;  5'd2: r = 8'd20;   5'd3: r = 8'd2;
      5'd4: r = 8'd40;   5'd5: r = 8'd4;    5'd6: r = 8'd80;   5'd7: r = 8'd6;
      5'd8: r = 8'd160;  5'd9: r = 8'd8;    5'd10: r = 8'd60;  5'd11: r = 8'd10;
      5'd12: r = 8'd14;  5'd13: r = 8'd12;  5'd14: r = 8'd26;  5'd15: r = 8'd14;
      5'd16: r = 8'd12;  5'd17: r = 8'd16;  5'd18: r = 8'd24;  5'd19: r = 8'd18;
      5'd20: r = 8'd48;  5'd21: r = 8'd20;  5'd22: r = 8'd96;  5'd23: r = 8'd22;
      5'd24: r = 8'd192; 5'd25: r = 8'd24;  5'd26: r = 8'd72;  5'd27: r = 8'd26;
      5'd28: r = 8'd16;  5'd29: r = 8'd28;  5'd30: r = 8'd32;  default: r = 8'd30;
    endcase
    return r;
  endfunction

  function automatic logic [11:0] noise_lookup(input logic [3:0] i);
    logic [11:0] r;
    case (i)
      4'd0: r = 12'd4;    4'd1: r = 12'd8;     4'd2: r = 12'd16;    4'd3: r = 12'd32;
      4'd4: r = 12'd64;   4'd5: r = 12'd96;    4'd6: r = 12'd128;   4'd7: r = 12'd160;
      4'd8: r = 12'd202;  4'd9: r = 12'd254;   4'd10: r = 12'd380;  4'd11: r = 12'd508;
      4'd12: r = 12'd762; 4'd13: r = 12'd1016; 4'd14: r = 12'd2034; default: r = 12'd4068;
    endcase
    return r;
  endfunction
endpackage

// File: hw/rtl/acu_envelope.sv
// one envelope unit: register write and quarter-frame step
module acu_envelope import acu_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       wr_ctrl_i,
  input  logic       restart_i,
  input  logic [7:0] wdata_i,
  input  logic       tick_i,
  output env_t       env_o
);
  env_t env_q, env_d;

  always_comb begin
    env_d = env_q;
    if (wr_ctrl_i) begin
      env_d.loop = wdata_i[5];
      env_d.constant = wdata_i[4];
      env_d.level = wdata_i[3:0];
    end
    if (restart_i) env_d.start = 1'b1;
    if (tick_i) begin
      if (env_q.start) begin
        env_d.start = 1'b0;
        env_d.decay = DECAY_FULL;
        env_d.divider = env_q.level;
      end else if (env_q.divider == 4'd0) begin
        env_d.divider = env_q.level;
        if (env_q.decay == 4'd0) begin
          if (env_q.loop) env_d.decay = DECAY_FULL;
        end else begin
          env_d.decay = env_q.decay - 4'd1;
        end
      end else begin
        env_d.divider = env_q.divider - 4'd1;
      end
      env_d.amplitude = env_q.constant ? env_q.level : env_d.decay;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) env_q <= '0;
    else env_q <= env_d;
  end

  assign env_o = env_q;
endmodule

// File: hw/rtl/acu_pulse_sweep.sv
// pulse period register with sweep unit
module acu_pulse_sweep import acu_pkg::*; #(
  parameter bit OnesComplement = 1'b1
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        wr_sweep_i,
  input  logic        wr_lo_i,
  input  logic        wr_hi_i,
  input  logic [7:0]  wdata_i,
  input  logic        half_i,
  output logic [10:0] period_o,
  output logic        mute_o
);
  logic [10:0] period_q, period_d;
  logic [7:0]  set_q, set_d;
  logic [2:0]  cnt_q, cnt_d;
  logic        mute_q, mute_d;
  logic [10:0] delta;
  logic [12:0] target;

  always_comb begin
    period_d = period_q;
    set_d = set_q;
    cnt_d = cnt_q;
    mute_d = mute_q;
    delta = period_q >> set_q[2:0];
    if (set_q[3])
      target = {2'b00, period_q} - {2'b00, delta} - (OnesComplement ? 13'd1 : 13'd0);
    else
      target = {2'b00, period_q} + {2'b00, delta};
    if (wr_sweep_i) set_d = wdata_i;
    if (wr_lo_i) period_d[7:0] = wdata_i;
    if (wr_hi_i) period_d[10:8] = wdata_i[2:0];
    if (half_i) begin
      if (set_q[7]) begin
        if (cnt_q == 3'd0) begin
          cnt_d = set_q[6:4];
          if (!target[12] && target < 13'h7FF && target >= 13'd8)
            period_d = target[10:0];
        end else begin
          cnt_d = cnt_q - 3'd1;
        end
      end
      mute_d = period_d < PERIOD_MIN;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= '0; set_q <= '0; cnt_q <= '0; mute_q <= 1'b0;
    end else begin
      period_q <= period_d; set_q <= set_d; cnt_q <= cnt_d; mute_q <= mute_d;
    end
  end

  assign period_o = period_q;
  assign mute_o = mute_q;
endmodule

// File: hw/rtl/audio_channel_control_unit.sv
// top level of the audio channel control unit
// One transfer in gives one transfer out, in the next cycle; a new item is taken every
// clock whenever the output is empty or is being drained in the same cycle.
// All channel state updates in a single pass of logic between the accepted item and
// the state registers. The result (status read data, volumes, gates, periods, duties
// as they stand after the item) is formed from those state registers while it waits,
// and the state cannot move then because the input is held off.
module audio_channel_control_unit import acu_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // op[1:0], addr[6:2], wdata[14:7], zero fill
  input  logic [15:0] s_axis_tdata_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // rdata, pulse1_volume, pulse2_volume, noise_volume, gate_mask, pulse1_period,
  // pulse2_period, triangle_period, duty_pair (each from the low bits up), zero fill
  output logic [63:0] m_axis_tdata_o
);
  logic       acc;
  logic [1:0] op;
  logic [4:0] addr;
  logic [7:0] wd;
  logic       wr, rd, tmr, qtr, half;

  // output drains or is empty: take the next item
  assign s_axis_tready_o = !m_axis_tvalid_o || m_axis_tready_i;
  assign acc  = s_axis_tvalid_i && s_axis_tready_o;
  assign op   = s_axis_tdata_i[1:0];
  assign addr = s_axis_tdata_i[6:2];
  assign wd   = s_axis_tdata_i[14:7];
  assign wr   = acc && (op == OP_WRITE);
  assign rd   = acc && (op == OP_READ);
  assign tmr  = acc && (op == OP_TIMER);
  assign qtr  = acc && (op == OP_QUARTER);

  // simple registers
  logic [1:0]  duty_q [2];
  logic [7:0]  len_q [4], len_d [4];
  logic [3:0]  en_q, en_d;
  logic [10:0] tri_per_q;
  logic        tri_ctl_q, tri_pend_q;
  logic [6:0]  tri_rel_q, tri_lin_q;
  logic        nmode_q;
  logic [11:0] nrel_q, ncnt_q;
  logic [2:0]  pre_q;
  logic [14:0] lfsr_q;
  logic        fmode_q, irqb_q, half_q;
  result_t     res_d;

  assign half = qtr && half_q;

  // envelopes: pulse 1, pulse 2, noise
  env_t env1, env2, envn;
  acu_envelope u_env1 (.clk_i, .rst_ni, .wr_ctrl_i(wr && addr == A_P1_CTRL),
    .restart_i(wr && addr == A_P1_HI), .wdata_i(wd), .tick_i(qtr), .env_o(env1));
  acu_envelope u_env2 (.clk_i, .rst_ni, .wr_ctrl_i(wr && addr == A_P2_CTRL),
    .restart_i(wr && addr == A_P2_HI), .wdata_i(wd), .tick_i(qtr), .env_o(env2));
  acu_envelope u_envn (.clk_i, .rst_ni, .wr_ctrl_i(wr && addr == A_NS_CTRL),
    .restart_i(wr && addr == A_NS_LEN), .wdata_i(wd), .tick_i(qtr), .env_o(envn));

  // sweeps: pulse 1 negates by ones' complement, pulse 2 by two's complement
  logic [10:0] p1_per, p2_per;
  logic        p1_mute, p2_mute;
  acu_pulse_sweep #(.OnesComplement(1'b1)) u_sw1 (.clk_i, .rst_ni,
    .wr_sweep_i(wr && addr == A_P1_SWEEP), .wr_lo_i(wr && addr == A_P1_LO),
    .wr_hi_i(wr && addr == A_P1_HI), .wdata_i(wd), .half_i(half),
    .period_o(p1_per), .mute_o(p1_mute));
  acu_pulse_sweep #(.OnesComplement(1'b0)) u_sw2 (.clk_i, .rst_ni,
    .wr_sweep_i(wr && addr == A_P2_SWEEP), .wr_lo_i(wr && addr == A_P2_LO),
    .wr_hi_i(wr && addr == A_P2_HI), .wdata_i(wd), .half_i(half),
    .period_o(p2_per), .mute_o(p2_mute));

  // length counters and enables
  logic [3:0] halt;
  assign halt = {envn.loop, tri_ctl_q, env2.loop, env1.loop};
  always_comb begin
    en_d = en_q;
    for (int c = 0; c < 4; c++) begin
      len_d[c] = len_q[c];
      if (half && !halt[c] && len_q[c] != 8'd0) len_d[c] = len_q[c] - 8'd1;
    end
    if (wr) begin
      case (addr)
        A_P1_HI:  len_d[0] = len_lookup(wd[7:3]);
        A_P2_HI:  len_d[1] = len_lookup(wd[7:3]);
        A_TRI_HI: len_d[2] = len_lookup(wd[7:3]);
        A_NS_LEN: len_d[3] = len_lookup(wd[7:3]);
        A_STATUS: begin
          en_d = wd[3:0];
          for (int c = 0; c < 4; c++) if (!wd[c]) len_d[c] = 8'd0;
        end
        default: ;
      endcase
    end
  end

  // noise lfsr next value; the noise timer steps once per seven timer ticks and moves the lfsr
  logic [14:0] lfsr_d;
  logic        fb;
  always_comb begin
    fb = (nmode_q ? lfsr_q[6] : lfsr_q[1]) ^ lfsr_q[0];
    lfsr_d = {fb, lfsr_q[14:1]};
  end

  // triangle linear counter next value
  logic [6:0] lin_d;
  always_comb begin
    lin_d = tri_lin_q;
    if (qtr) begin
      if (tri_pend_q) lin_d = tri_rel_q;
      else if (tri_lin_q != 7'd0) lin_d = tri_lin_q - 7'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      duty_q <= '{default: '0};
      len_q <= '{default: '0};
      en_q <= '0;
      tri_per_q <= '0; tri_ctl_q <= 1'b0; tri_pend_q <= 1'b0;
      tri_rel_q <= '0; tri_lin_q <= '0;
      nmode_q <= 1'b0; nrel_q <= '0; ncnt_q <= '0; pre_q <= '0;
      lfsr_q <= 15'd1;
      fmode_q <= 1'b0; irqb_q <= 1'b0; half_q <= 1'b0;
    end else begin
      len_q <= len_d;
      en_q <= en_d;
      tri_lin_q <= lin_d;
      if (wr) begin
        case (addr)
          A_P1_CTRL: duty_q[0] <= wd[7:6];
          A_P2_CTRL: duty_q[1] <= wd[7:6];
          A_TRI_LIN: begin tri_ctl_q <= wd[7]; tri_rel_q <= wd[6:0]; end
          A_TRI_LO:  tri_per_q[7:0] <= wd;
          A_TRI_HI:  begin tri_per_q[10:8] <= wd[2:0]; tri_pend_q <= 1'b1; end
          A_NS_PER:  begin nmode_q <= wd[7]; nrel_q <= noise_lookup(wd[3:0]); end
          A_FRAME:   begin fmode_q <= wd[7]; irqb_q <= wd[6]; end
          default: ;
        endcase
      end
      if (qtr) begin
        if (!tri_ctl_q) tri_pend_q <= 1'b0;
        half_q <= !half_q;
      end
      if (tmr) begin
        if (pre_q == 3'd0) begin
          pre_q <= PRESCALE_RELOAD;
          if (en_q[3]) begin
            if (ncnt_q == 12'd0) begin
              ncnt_q <= nrel_q;
              lfsr_q <= lfsr_d;
            end else begin
              ncnt_q <= ncnt_q - 12'd1;
            end
          end
        end else begin
          pre_q <= pre_q - 3'd1;
        end
      end
    end
  end

  // state registers hold the post-item state in the cycle after acceptance, so the
  // result is formed from them as it leaves; a read leaves the lengths unchanged
  logic rd_q, res_pend_q;
  logic [3:0] stat_now;
  always_comb
    for (int c = 0; c < 4; c++) stat_now[c] = len_q[c] != 8'd0;

  always_comb begin
    res_d.rdata = rd_q ? stat_now : 4'd0;
    res_d.pulse1_volume = env1.amplitude;
    res_d.pulse2_volume = env2.amplitude;
    res_d.noise_volume = envn.amplitude;
    res_d.gate_mask[0] = en_q[0] && p1_per >= PERIOD_MIN && len_q[0] != 8'd0 &&
                         env1.amplitude != 4'd0 && !p1_mute;
    res_d.gate_mask[1] = en_q[1] && p2_per >= PERIOD_MIN && len_q[1] != 8'd0 &&
                         env2.amplitude != 4'd0 && !p2_mute;
    res_d.gate_mask[2] = en_q[2] && len_q[2] != 8'd0 && tri_lin_q != 7'd0;
    res_d.gate_mask[3] = en_q[3] && len_q[3] != 8'd0 && envn.amplitude != 4'd0 &&
                         !lfsr_q[0];
    res_d.pulse1_period = p1_per;
    res_d.pulse2_period = p2_per;
    res_d.triangle_period = tri_per_q;
    res_d.duty_pair = {duty_q[1], duty_q[0]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_pend_q <= 1'b0;
      rd_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      res_pend_q <= acc;
      rd_q <= rd && addr == A_STATUS;
    end
  end

  assign m_axis_tvalid_o = res_pend_q;
  assign m_axis_tdata_o = {7'd0, res_d.duty_pair, res_d.triangle_period,
    res_d.pulse2_period, res_d.pulse1_period, res_d.gate_mask, res_d.noise_volume,
    res_d.pulse2_volume, res_d.pulse1_volume, res_d.rdata};
  logic unused;
  assign unused = fmode_q ^ irqb_q;
endmodule

// File: hw/rtl/acu_checker.sv
// port-level checker for the audio channel control unit
`include "assert_macros.svh"
module acu_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic [15:0] s_axis_tdata_i,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [63:0] m_axis_tdata_o
);
  `ASSERT_IMPL(a_ready_free, clk_i, rst_ni, !m_axis_tvalid_o, s_axis_tready_o)
  `ASSERT_NEXT(a_one_out, clk_i, rst_ni, s_axis_tvalid_i && s_axis_tready_o,
    m_axis_tvalid_o)
  `ASSERT_NEXT(a_no_in, clk_i, rst_ni, !s_axis_tvalid_i && s_axis_tready_o,
    !m_axis_tvalid_o)
  `ASSERT_IMPL(a_fill, clk_i, rst_ni, m_axis_tvalid_o, m_axis_tdata_o[63:57] == 7'd0)
endmodule

bind audio_channel_control_unit acu_checker u_acu_checker (.*);

// File: verif/tb_top.sv
// testbench for the audio channel control unit: random and directed items against a predictor
`timescale 1ns / 1ps

module tb_top;
  import acu_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [15:0] s_axis_tdata_i = '0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [63:0] m_axis_tdata_o;

  audio_channel_control_unit dut (
    .clk_i, .rst_ni, .s_axis_tvalid_i, .s_axis_tready_o, .s_axis_tdata_i,
    .m_axis_tvalid_o, .m_axis_tready_i, .m_axis_tdata_o
  );

  always #2 clk_i = ~clk_i;

  typedef struct packed {
    logic [7:0] wdata;
    logic [4:0] addr;
    op_e        op;
  } item_t;

  // channel state mirror
  logic [10:0] p_period [2];
  logic [1:0]  p_duty [2];
  logic [7:0]  len_cnt [4];
  logic        ch_en [4];
  logic        e_start [3], e_loop [3], e_const [3];
  logic [3:0]  e_level [3], e_div [3], e_decay [3], e_amp [3];
  logic [7:0]  sw_set [2];
  logic [2:0]  sw_cnt [2];
  logic        sw_mute [2];
  logic [10:0] tri_per;
  logic        tri_ctrl, tri_pend;
  logic [6:0]  tri_rel, tri_lin;
  logic        nz_mode;
  logic [11:0] nz_reload, nz_cnt;
  logic [2:0]  presc;
  logic [14:0] lfsr;
  logic        frame_mode, irq_block, half_tog;

  item_t   pending_items[$];
  result_t expected_results[$];
  int      errors = 0;
  bit      stim_done = 0;
  bit      hold_sink = 0;

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %s: got %0h want %0h", what, got, want);
    errors++;
  endtask

  function automatic void clear_state();
    for (int i = 0; i < 2; i++) begin
      p_period[i] = '0; p_duty[i] = '0; sw_set[i] = '0; sw_cnt[i] = '0; sw_mute[i] = 0;
    end
    for (int i = 0; i < 4; i++) begin
      len_cnt[i] = '0; ch_en[i] = 0;
    end
    for (int i = 0; i < 3; i++) begin
      e_start[i] = 0; e_loop[i] = 0; e_const[i] = 0;
      e_level[i] = '0; e_div[i] = '0; e_decay[i] = '0; e_amp[i] = '0;
    end
    tri_per = '0; tri_ctrl = 0; tri_rel = '0; tri_lin = '0; tri_pend = 0;
    nz_mode = 0; nz_reload = '0; nz_cnt = '0; presc = '0; lfsr = 15'd1;
    frame_mode = 0; irq_block = 0; half_tog = 0;
  endfunction

  function automatic void env_clock(input int e);
    if (e_start[e]) begin
      e_start[e] = 0; e_decay[e] = 4'd15; e_div[e] = e_level[e];
    end else if (e_div[e] == 0) begin
      e_div[e] = e_level[e];
      if (e_decay[e] == 0) begin
        if (e_loop[e]) e_decay[e] = 4'd15;
      end else e_decay[e]--;
    end else e_div[e]--;
    e_amp[e] = e_const[e] ? e_level[e] : e_decay[e];
  endfunction

  function automatic void sweep_clock(input int c);
    int delta, target;
    if (sw_set[c][7]) begin
      if (sw_cnt[c] == 0) begin
        delta = int'(p_period[c] >> sw_set[c][2:0]);
        sw_cnt[c] = sw_set[c][6:4];
        if (sw_set[c][3]) delta = (c == 0) ? -delta - 1 : -delta;
        target = int'(p_period[c]) + delta;
        if (target < 'h7FF && target >= 8) p_period[c] = target[10:0];
      end else sw_cnt[c]--;
    end
    sw_mute[c] = p_period[c] < 11'd8;
  endfunction

  // applies one item to the mirror and returns the outputs after it
  function automatic result_t channel_step(input item_t it);
    result_t r;
    logic [7:0] d;
    int c;
    d = it.wdata;
    r = '0;
    case (it.op)
      OP_WRITE: begin
        case (it.addr)
          A_P1_CTRL, A_P2_CTRL: begin
            c = (it.addr == A_P1_CTRL) ? 0 : 1;
            e_loop[c] = d[5]; e_const[c] = d[4]; e_level[c] = d[3:0]; p_duty[c] = d[7:6];
          end
          A_P1_SWEEP: sw_set[0] = d;
          A_P2_SWEEP: sw_set[1] = d;
          A_P1_LO, A_P2_LO: begin
            c = (it.addr == A_P1_LO) ? 0 : 1;
            p_period[c][7:0] = d;
          end
          A_P1_HI, A_P2_HI: begin
            c = (it.addr == A_P1_HI) ? 0 : 1;
            len_cnt[c] = len_lookup(d[7:3]); p_period[c][10:8] = d[2:0]; e_start[c] = 1;
          end
          A_TRI_LIN: begin tri_ctrl = d[7]; tri_rel = d[6:0]; end
          A_TRI_LO: tri_per[7:0] = d;
          A_TRI_HI: begin
            tri_per[10:8] = d[2:0]; len_cnt[2] = len_lookup(d[7:3]); tri_pend = 1;
          end
          A_NS_CTRL: begin e_loop[2] = d[5]; e_const[2] = d[4]; e_level[2] = d[3:0]; end
          A_NS_PER: begin nz_mode = d[7]; nz_reload = noise_lookup(d[3:0]); end
          A_NS_LEN: begin len_cnt[3] = len_lookup(d[7:3]); e_start[2] = 1; end
          A_STATUS: for (int i = 0; i < 4; i++) begin
            ch_en[i] = d[i];
            if (!d[i]) len_cnt[i] = '0;
          end
          A_FRAME: begin frame_mode = d[7]; irq_block = d[6]; end
          default: ;
        endcase
      end
      OP_READ: if (it.addr == A_STATUS)
        for (int i = 0; i < 4; i++) r.rdata[i] = len_cnt[i] != 0;
      OP_TIMER: begin
        if (presc == 0) begin
          presc = 3'd6;
          if (ch_en[3]) begin
            if (nz_cnt == 0) begin
              nz_cnt = nz_reload;
              lfsr = {(nz_mode ? lfsr[6] : lfsr[1]) ^ lfsr[0], lfsr[14:1]};
            end else nz_cnt--;
          end
        end else presc--;
      end
      default: begin
        for (int e = 0; e < 3; e++) env_clock(e);
        if (tri_pend) tri_lin = tri_rel;
        else if (tri_lin > 0) tri_lin--;
        if (!tri_ctrl) tri_pend = 0;
        if (half_tog) begin
          half_tog = 0;
          if (!e_loop[0] && len_cnt[0] > 0) len_cnt[0]--;
          if (!e_loop[1] && len_cnt[1] > 0) len_cnt[1]--;
          if (!tri_ctrl && len_cnt[2] > 0) len_cnt[2]--;
          if (!e_loop[2] && len_cnt[3] > 0) len_cnt[3]--;
          sweep_clock(0);
          sweep_clock(1);
        end else half_tog = 1;
      end
    endcase
    for (int i = 0; i < 2; i++)
      r.gate_mask[i] = ch_en[i] && p_period[i] >= 11'd8 && len_cnt[i] > 0 &&
                       e_amp[i] > 0 && !sw_mute[i];
    r.gate_mask[2] = ch_en[2] && len_cnt[2] > 0 && tri_lin > 0;
    r.gate_mask[3] = ch_en[3] && len_cnt[3] > 0 && e_amp[2] > 0 && !lfsr[0];
    r.pulse1_volume = e_amp[0];
    r.pulse2_volume = e_amp[1];
    r.noise_volume = e_amp[2];
    r.pulse1_period = p_period[0];
    r.pulse2_period = p_period[1];
    r.triangle_period = tri_per;
    r.duty_pair = {p_duty[1], p_duty[0]};
    return r;
  endfunction

  function automatic item_t mk(input op_e op, input logic [4:0] a, input logic [7:0] d);
    item_t it;
    it.op = op; it.addr = a; it.wdata = d;
    return it;
  endfunction

  // register offsets that do something, for well-formed random writes
  logic [4:0] live_regs [16] = '{A_P1_CTRL, A_P1_SWEEP, A_P1_LO, A_P1_HI, A_P2_CTRL,
    A_P2_SWEEP, A_P2_LO, A_P2_HI, A_TRI_LIN, A_TRI_LO, A_TRI_HI, A_NS_CTRL, A_NS_PER,
    A_NS_LEN, A_STATUS, A_FRAME};

  function automatic item_t random_item();
    int k;
    k = $urandom_range(0, 99);
    if (k < 35) return mk(OP_WRITE, live_regs[$urandom_range(0, 15)], 8'($urandom));
    if (k < 40) return mk(OP_WRITE, 5'($urandom), 8'($urandom));
    if (k < 48) return mk(OP_READ, ($urandom_range(0, 1) != 0) ? A_STATUS : 5'($urandom),
                          8'($urandom));
    if (k < 70) return mk(OP_TIMER, 5'($urandom), 8'($urandom));
    return mk(OP_QUARTER, 5'($urandom), 8'($urandom));
  endfunction

  // stimulus
  initial begin
    clear_state();
    // directed: enables, full-range fields, downward sweeps on both pulses, halts, noise modes
    pending_items.push_back(mk(OP_READ, A_STATUS, 8'h00));
    pending_items.push_back(mk(OP_WRITE, A_STATUS, 8'hFF));
    pending_items.push_back(mk(OP_WRITE, A_P1_CTRL, 8'hFF));
    pending_items.push_back(mk(OP_WRITE, A_P2_CTRL, 8'h0F));
    pending_items.push_back(mk(OP_WRITE, A_P1_SWEEP, 8'h89));
    pending_items.push_back(mk(OP_WRITE, A_P2_SWEEP, 8'hF9));
    pending_items.push_back(mk(OP_WRITE, A_P1_LO, 8'hFF));
    pending_items.push_back(mk(OP_WRITE, A_P1_HI, 8'hFF));
    pending_items.push_back(mk(OP_WRITE, A_P2_LO, 8'h40));
    pending_items.push_back(mk(OP_WRITE, A_P2_HI, 8'h0A));
    pending_items.push_back(mk(OP_WRITE, A_TRI_LIN, 8'h85));
    pending_items.push_back(mk(OP_WRITE, A_TRI_LO, 8'hFF));
    pending_items.push_back(mk(OP_WRITE, A_TRI_HI, 8'hF8));
    pending_items.push_back(mk(OP_WRITE, A_NS_CTRL, 8'h3F));
    pending_items.push_back(mk(OP_WRITE, A_NS_PER, 8'h80));
    pending_items.push_back(mk(OP_WRITE, A_NS_LEN, 8'h08));
    pending_items.push_back(mk(OP_WRITE, A_FRAME, 8'hC0));
    pending_items.push_back(mk(OP_WRITE, 5'h1F, 8'hFF));
    for (int i = 0; i < 3; i++) pending_items.push_back(mk(OP_QUARTER, 5'h1F, 8'hFF));
    for (int i = 0; i < 3; i++) pending_items.push_back(mk(OP_TIMER, 5'h00, 8'h00));
    pending_items.push_back(mk(OP_READ, A_STATUS, 8'hFF));
    pending_items.push_back(mk(OP_WRITE, A_STATUS, 8'h00));
    pending_items.push_back(mk(OP_READ, 5'h17, 8'h00));
    // noise burst so the lfsr moves in both modes
    pending_items.push_back(mk(OP_WRITE, A_STATUS, 8'h0F));
    pending_items.push_back(mk(OP_WRITE, A_NS_PER, 8'h00));
    for (int i = 0; i < 100; i++) pending_items.push_back(mk(OP_TIMER, 5'($urandom), 8'h00));
    pending_items.push_back(mk(OP_WRITE, A_NS_PER, 8'h80));
    for (int i = 0; i < 100; i++) pending_items.push_back(mk(OP_TIMER, 5'($urandom), 8'h00));
    for (int i = 0; i < 520; i++) pending_items.push_back(random_item());
    for (int i = 0; i < 7; i++) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // driver: one hold-off pause after the first 24 items until drained
  int sent = 0;
  int gap = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        expected_results.push_back(channel_step(item_t'(s_axis_tdata_i[14:0])));
        sent++;
        gap = $urandom_range(0, 7);
        if (($urandom_range(0, 3) == 0) || (sent > 400 && sent < 500)) gap = 0;
      end
      if (s_axis_tvalid_i && !s_axis_tready_o) begin
        // keep offering
      end else if (sent == 24 && expected_results.size() != 0) begin
        s_axis_tvalid_i <= 1'b0;
      end else if (gap > 0) begin
        gap--;
        s_axis_tvalid_i <= 1'b0;
      end else if (pending_items.size() != 0) begin
        s_axis_tvalid_i <= 1'b1;
        s_axis_tdata_i <= {1'b0, pending_items.pop_front()};
      end else begin
        s_axis_tvalid_i <= 1'b0;
        stim_done = 1;
      end
    end
  end

  // receiver stalls: a long hold-off while the sender keeps offering
  initial begin
    wait (sent >= 300);
    hold_sink = 1;
    for (int i = 0; i < 60; i++) @(posedge clk_i);
    hold_sink = 0;
  end

  int stall = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        result_t want, got;
        got.rdata = m_axis_tdata_o[3:0];
        got.pulse1_volume = m_axis_tdata_o[7:4];
        got.pulse2_volume = m_axis_tdata_o[11:8];
        got.noise_volume = m_axis_tdata_o[15:12];
        got.gate_mask = m_axis_tdata_o[19:16];
        got.pulse1_period = m_axis_tdata_o[30:20];
        got.pulse2_period = m_axis_tdata_o[41:31];
        got.triangle_period = m_axis_tdata_o[52:42];
        got.duty_pair = m_axis_tdata_o[56:53];
        if (expected_results.size() == 0) report("unexpected transfer", 0, 0);
        else begin
          want = expected_results.pop_front();
          if (got.rdata != want.rdata) report("rdata", got.rdata, want.rdata);
          if (got.pulse1_volume != want.pulse1_volume)
            report("pulse1_volume", got.pulse1_volume, want.pulse1_volume);
          if (got.pulse2_volume != want.pulse2_volume)
            report("pulse2_volume", got.pulse2_volume, want.pulse2_volume);
          if (got.noise_volume != want.noise_volume)
            report("noise_volume", got.noise_volume, want.noise_volume);
          if (got.gate_mask != want.gate_mask) report("gate_mask", got.gate_mask, want.gate_mask);
          if (got.pulse1_period != want.pulse1_period)
            report("pulse1_period", got.pulse1_period, want.pulse1_period);
          if (got.pulse2_period != want.pulse2_period)
            report("pulse2_period", got.pulse2_period, want.pulse2_period);
          if (got.triangle_period != want.triangle_period)
            report("triangle_period", got.triangle_period, want.triangle_period);
          if (got.duty_pair != want.duty_pair) report("duty_pair", got.duty_pair, want.duty_pair);
        end
        stall = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 7);
        if (sent > 600 && sent < 700) stall = 0;
      end
      if (hold_sink) m_axis_tready_i <= 1'b0;
      else if (stall > 0) begin
        stall--;
        m_axis_tready_i <= 1'b0;
      end else m_axis_tready_i <= 1'b1;
    end
  end

  // end of run
  initial begin
    wait (stim_done && expected_results.size() == 0);
    for (int i = 0; i < 10; i++) @(posedge clk_i);
    if (errors == 0) $display("tb_top: clean");
    else $display("tb_top: errors");
    $finish;
  end

  initial begin
    #400000;
    $display("tb_top: errors");
    $finish;
  end
endmodule

// File: files.f
+incdir+hw/rtl
hw/rtl/acu_pkg.sv
hw/rtl/acu_envelope.sv
hw/rtl/acu_pulse_sweep.sv
hw/rtl/audio_channel_control_unit.sv
hw/rtl/acu_checker.sv
verif/tb_top.sv
